@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the decoder RTL.
// Depends on nothing; the asserting module supplies signals named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HFD_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HFD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/hfd_pkg.sv @@
// Shared types and constants of the tree-walk decoder.
// Depends on nothing; used by the interfaces, the node memory and the top level.
package hfd_pkg;

   localparam int IDX_W          = 9;
   localparam int SYM_W          = 8;
   localparam int DATA_W         = 8;
   localparam int CNT_W          = 32;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 32;
   localparam int NODE_COUNT_DEF = 512;

   // Walk counter runs from the priming cycle (0) to the last bit (DATA_W).
   localparam int                    WALK_CNT_W = $clog2(DATA_W + 1);
   localparam logic [WALK_CNT_W-1:0] WALK_LAST  = WALK_CNT_W'(DATA_W);

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_DECODE = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROOT  = 2'd0,
      CSR_TOTAL = 2'd1
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN
   } state_type;

   // One node table entry.
   typedef struct packed {
      logic             leaf;
      logic [SYM_W-1:0] symbol;
      logic [IDX_W-1:0] left;
      logic [IDX_W-1:0] right;
   } node_type;

endpackage

@@ rtl/core/hfd_ifs.sv @@
// Valid/ready channel interfaces of the decoder: request, response and register write.
// Depends on hfd_pkg for field widths.
interface hfd_req_if;
   logic                           valid;
   logic                           ready;
   hfd_pkg::op_type                op;
   logic [hfd_pkg::IDX_W-1:0]      node_index;
   logic                           node_is_leaf;
   logic [hfd_pkg::SYM_W-1:0]      node_symbol;
   logic [hfd_pkg::IDX_W-1:0]      left_child;
   logic [hfd_pkg::IDX_W-1:0]      right_child;
   logic [hfd_pkg::DATA_W-1:0]     data_byte;

   modport source (output valid, op, node_index, node_is_leaf, node_symbol,
                   left_child, right_child, data_byte, input ready);
   modport sink   (input valid, op, node_index, node_is_leaf, node_symbol,
                   left_child, right_child, data_byte, output ready);
endinterface

interface hfd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [hfd_pkg::SYM_W-1:0]  symbol;
   logic                       last;
   logic                       finished;

   modport source (output valid, symbol, last, finished, input ready);
   modport sink   (input valid, symbol, last, finished, output ready);
endinterface

interface hfd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [hfd_pkg::CSR_IDX_W-1:0]   index;
   logic [hfd_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/huffman_tree_walk_decoder.sv @@
// Top level of the tree-walk decoder: handshakes, bit-serial walk and result queueing.
// Depends on hfd_pkg, the channel interfaces, hfd_node_mem and assert_macros.svh.
//
//  Channel   Dir   Carries
//  req_chan  in    load a node (op 0) or decode one byte (op 1)
//  rsp_chan  out   decoded symbol, last-of-byte flag, finished flag
//  csr_chan  in    register write: root_node (0), total_symbols (1)
//
// A decode runs through the transfer, a read of the current node, one step per data
// bit and a final step that hands over the final symbol. Each bit needs one node table
// read through the registered read port, which sets the one-bit-per-cycle pace while
// the response side keeps up.
// Reset is synchronous and active high; the node table itself is not cleared.
// A stalled response stalls the walk at the next symbol; requests are taken only
// when no walk is in progress.
`include "assert_macros.svh"

module huffman_tree_walk_decoder #(
   parameter int NODE_COUNT = hfd_pkg::NODE_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   hfd_req_if.sink     req_chan,
   hfd_rsp_if.source   rsp_chan,
   hfd_csr_if.sink     csr_chan
);

   localparam int ADDR_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
   localparam logic [hfd_pkg::IDX_W:0] NODE_LIMIT = (hfd_pkg::IDX_W + 1)'(NODE_COUNT);

   // Control state.
   hfd_pkg::state_type                  state_ff, state_in;
   logic [hfd_pkg::WALK_CNT_W-1:0]      bit_cnt_ff, bit_cnt_in;
   logic [hfd_pkg::IDX_W-1:0]           root_ff, root_in;
   logic [hfd_pkg::IDX_W-1:0]           cur_ff, cur_in;
   logic [hfd_pkg::CNT_W-1:0]           total_ff, total_in;
   logic [hfd_pkg::CNT_W-1:0]           emitted_ff, emitted_in;
   logic                                pend_valid_ff, pend_valid_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   // Payload state.
   logic [hfd_pkg::DATA_W-1:0]          bits_ff, bits_in;
   logic [hfd_pkg::IDX_W-1:0]           rd_addr_ff;
   logic                                rd_oor_ff;
   logic                                root_oor_ff;
   logic [hfd_pkg::SYM_W-1:0]           pend_sym_ff, pend_sym_in;
   logic                                pend_fin_ff, pend_fin_in;
   logic [hfd_pkg::SYM_W-1:0]           rsp_sym_ff, rsp_sym_in;
   logic                                rsp_last_ff, rsp_last_in;
   logic                                rsp_fin_ff, rsp_fin_in;

   // Walk datapath.
   logic                                req_accept;
   logic                                csr_accept;
   logic                                slot_free;
   logic                                first;
   logic                                reached;
   logic                                emit;
   logic                                stall;
   logic [hfd_pkg::IDX_W-1:0]           cur_idx;
   logic [hfd_pkg::IDX_W-1:0]           next_hit;
   logic [hfd_pkg::IDX_W-1:0]           mem_addr;
   logic                                mem_oor;
   logic                                root_oor;
   logic                                wr_en;
   hfd_pkg::node_type                   wr_data;
   hfd_pkg::node_type                   rd_a_data;
   hfd_pkg::node_type                   rd_b_data;
   hfd_pkg::node_type                   hit_ent;
   hfd_pkg::node_type                   root_ent;
   hfd_pkg::node_type                   cur_ent;

   // Handshakes: requests and register writes are taken only between walks.
   assign csr_chan.ready = (state_ff == hfd_pkg::ST_IDLE);
   assign req_chan.ready = (state_ff == hfd_pkg::ST_IDLE) && !csr_chan.valid;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign csr_accept     = csr_chan.valid && csr_chan.ready;

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.symbol   = rsp_sym_ff;
   assign rsp_chan.last     = rsp_last_ff;
   assign rsp_chan.finished = rsp_fin_ff;

   // Node loads; indexes beyond the table are dropped.
   assign wr_en = req_accept && (req_chan.op == hfd_pkg::OP_LOAD)
                  && ({1'b0, req_chan.node_index} < NODE_LIMIT);
   assign wr_data = '{leaf:   req_chan.node_is_leaf,
                      symbol: req_chan.node_symbol,
                      left:   req_chan.left_child,
                      right:  req_chan.right_child};

   // Out-of-range reads are steered to entry zero and masked to an empty node.
   assign mem_oor  = ({1'b0, mem_addr} >= NODE_LIMIT);
   assign root_oor = ({1'b0, root_ff} >= NODE_LIMIT);

   hfd_node_mem #(
      .NODE_COUNT (NODE_COUNT)
   ) u_node_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (req_chan.node_index[ADDR_W-1:0]),
      .wr_data   (wr_data),
      .rd_a_addr (mem_oor ? '0 : mem_addr[ADDR_W-1:0]),
      .rd_a_data (rd_a_data),
      .rd_b_addr (root_oor ? '0 : root_ff[ADDR_W-1:0]),
      .rd_b_data (rd_b_data)
   );

   assign hit_ent  = rd_oor_ff   ? '0 : rd_a_data;
   assign root_ent = root_oor_ff ? '0 : rd_b_data;

   // One bit step: look at the entry just read, then pick the next node to read.
   always_comb begin
      slot_free = !rsp_valid_ff || rsp_chan.ready;
      first     = (bit_cnt_ff == '0);
      reached   = !first && hit_ent.leaf;
      emit      = (state_ff == hfd_pkg::ST_WALK) && reached && (emitted_ff < total_ff);
      stall     = emit && pend_valid_ff && !slot_free;
      cur_idx   = reached ? root_ff : rd_addr_ff;
      cur_ent   = reached ? root_ent : hit_ent;
      if (cur_ent.leaf) begin
         next_hit = cur_idx;
      end else if (bits_ff[hfd_pkg::DATA_W-1]) begin
         next_hit = cur_ent.right;
      end else begin
         next_hit = cur_ent.left;
      end
   end

   // Next state and next values of all registers.
   always_comb begin
      state_in      = state_ff;
      bit_cnt_in    = bit_cnt_ff;
      root_in       = root_ff;
      cur_in        = cur_ff;
      total_in      = total_ff;
      emitted_in    = emitted_ff;
      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      pend_fin_in   = pend_fin_ff;
      bits_in       = bits_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sym_in    = rsp_sym_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_fin_in    = rsp_fin_ff;
      mem_addr      = cur_ff;

      // The output register empties when its transfer completes.
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         hfd_pkg::ST_IDLE: begin
            if (req_accept && (req_chan.op == hfd_pkg::OP_DECODE)) begin
               state_in   = hfd_pkg::ST_WALK;
               bits_in    = req_chan.data_byte;
               bit_cnt_in = '0;
            end
         end
         hfd_pkg::ST_WALK: begin
            if (stall) begin
               mem_addr = rd_addr_ff;
            end else begin
               mem_addr   = next_hit;
               cur_in     = cur_idx;
               bits_in    = bits_ff << 1;
               bit_cnt_in = bit_cnt_ff + 1'b1;
               if (bit_cnt_ff == hfd_pkg::WALK_LAST) begin
                  state_in = hfd_pkg::ST_DRAIN;
               end
               if (emit) begin
                  // The held symbol is not the byte's last, so it goes out now.
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_sym_in   = pend_sym_ff;
                     rsp_last_in  = 1'b0;
                     rsp_fin_in   = pend_fin_ff;
                  end
                  emitted_in    = emitted_ff + 1'b1;
                  pend_valid_in = 1'b1;
                  pend_sym_in   = hit_ent.symbol;
                  pend_fin_in   = ((emitted_ff + 1'b1) == total_ff);
               end
            end
         end
         hfd_pkg::ST_DRAIN: begin
            // The held symbol is the last of this byte.
            if (!pend_valid_ff) begin
               state_in = hfd_pkg::ST_IDLE;
            end else if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sym_in    = pend_sym_ff;
               rsp_last_in   = 1'b1;
               rsp_fin_in    = pend_fin_ff;
               pend_valid_in = 1'b0;
               state_in      = hfd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hfd_pkg::ST_IDLE;
         end
      endcase

      // Register writes; writing the root also restarts the walk there.
      if (csr_accept) begin
         case (csr_chan.index)
            hfd_pkg::CSR_ROOT: begin
               root_in = csr_chan.data[hfd_pkg::IDX_W-1:0];
               cur_in  = csr_chan.data[hfd_pkg::IDX_W-1:0];
            end
            hfd_pkg::CSR_TOTAL: begin
               total_in = csr_chan.data;
            end
            default: begin
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= hfd_pkg::ST_IDLE;
         bit_cnt_ff    <= '0;
         root_ff       <= '0;
         cur_ff        <= '0;
         total_ff      <= '0;
         emitted_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bit_cnt_ff    <= bit_cnt_in;
         root_ff       <= root_in;
         cur_ff        <= cur_in;
         total_ff      <= total_in;
         emitted_ff    <= emitted_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers, including the address that pairs with the read data.
   always_ff @(posedge clock) begin
      bits_ff     <= bits_in;
      rd_addr_ff  <= mem_addr;
      rd_oor_ff   <= mem_oor;
      root_oor_ff <= root_oor;
      pend_sym_ff <= pend_sym_in;
      pend_fin_ff <= pend_fin_in;
      rsp_sym_ff  <= rsp_sym_in;
      rsp_last_ff <= rsp_last_in;
      rsp_fin_ff  <= rsp_fin_in;
   end

   // Checks on the walk and the symbol queue.
   `HFD_ASSERT_NEXT(a_emit_counts, emit && !stall, emitted_ff == $past(emitted_ff) + 1'b1, "symbol emitted without count step")
   `HFD_ASSERT_NEXT(a_count_holds, (state_ff == hfd_pkg::ST_WALK) && (emitted_ff == total_ff), emitted_ff == $past(emitted_ff), "count moved past total")
   `HFD_ASSERT_NEXT(a_drain_empties, (state_ff == hfd_pkg::ST_DRAIN) && (state_in == hfd_pkg::ST_IDLE), !pend_valid_ff, "held symbol left behind")
   `HFD_ASSERT_SAME(a_idle_no_pending, state_ff == hfd_pkg::ST_IDLE, !pend_valid_ff, "held symbol while idle")

endmodule

@@ rtl/core/hfd_node_mem.sv @@
// Node table storage: one write port and two registered read ports.
// Depends on hfd_pkg for the entry type.
module hfd_node_mem #(
   parameter int  NODE_COUNT = hfd_pkg::NODE_COUNT_DEF,
   localparam int ADDR_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  hfd_pkg::node_type wr_data,
   input  logic [ADDR_W-1:0] rd_a_addr,
   output hfd_pkg::node_type rd_a_data,
   input  logic [ADDR_W-1:0] rd_b_addr,
   output hfd_pkg::node_type rd_b_data
);

   hfd_pkg::node_type mem [NODE_COUNT];
   hfd_pkg::node_type rd_a_ff;
   hfd_pkg::node_type rd_b_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Two read ports, data registered.
   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

@@ tb/huffman_tree_walk_decoder_tb.sv @@
// Self-checking testbench for the tree-walk decoder: loads node tables, decodes bytes
// and checks every decoded symbol against a behavioural predictor of the table walk.
// Depends on hfd_pkg, the channel interfaces in hfd_ifs.sv and the decoder RTL.
`timescale 1ns / 100ps

module huffman_tree_walk_decoder_tb;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int IDLE_CYCLES  = 16;
   localparam int FINAL_CYCLES = 32;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 60;
   localparam int REPORT_LINES = 100;

   // Register indexes that the block does not decode.
   localparam logic [hfd_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [hfd_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct {
      hfd_pkg::op_type            op;
      logic [hfd_pkg::IDX_W-1:0]  node_index;
      logic                       node_is_leaf;
      logic [hfd_pkg::SYM_W-1:0]  node_symbol;
      logic [hfd_pkg::IDX_W-1:0]  left_child;
      logic [hfd_pkg::IDX_W-1:0]  right_child;
      logic [hfd_pkg::DATA_W-1:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic [hfd_pkg::SYM_W-1:0] symbol;
      logic                      last;
      logic                      finished;
   } sym_result_type;

   logic clock;
   logic reset;

   hfd_req_if req_if ();
   hfd_rsp_if rsp_if ();
   hfd_csr_if csr_if ();

   huffman_tree_walk_decoder u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // Predictor state: node table, walk position, emitted count and registers.
   hfd_pkg::node_type          node_tbl [hfd_pkg::NODE_COUNT_DEF];
   bit                         node_written [hfd_pkg::NODE_COUNT_DEF];
   logic [hfd_pkg::IDX_W-1:0]  written_list [$];
   logic [hfd_pkg::IDX_W-1:0]  walk_node   = '0;
   logic [hfd_pkg::IDX_W-1:0]  root_reg    = '0;
   logic [hfd_pkg::CNT_W-1:0]  total_reg   = '0;
   logic [hfd_pkg::CNT_W-1:0]  emit_count  = '0;
   sym_result_type             pending_symbols [$];

   int error_count  = 0;
   int items_sent   = 0;
   int burst_left   = 0;
   int cycle_count  = 0;
   bit gaps_enabled = 1'b1;
   bit hold_request = 1'b0;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run limit; reaching it means the block has hung.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= REPORT_LINES)
         $display("%0t ERROR %s: got %0h, want %0h", $time, what, got, want);
   endtask

   // Walk the table for one byte, most significant bit first, and queue the symbols.
   function automatic void predict_decode(input logic [hfd_pkg::DATA_W-1:0] data_in);
      sym_result_type            batch [$];
      sym_result_type            res;
      logic [hfd_pkg::IDX_W-1:0] hit;
      logic                      reached;
      for (int b = hfd_pkg::DATA_W - 1; b >= 0; b--) begin
         reached = 1'b0;
         if (node_tbl[walk_node].leaf) begin
            // A leaf as the current node emits itself straight away.
            hit     = walk_node;
            reached = 1'b1;
         end else begin
            hit = data_in[b] ? node_tbl[walk_node].right : node_tbl[walk_node].left;
            if (node_tbl[hit].leaf)
               reached = 1'b1;
            else
               walk_node = hit;
         end
         if (reached) begin
            walk_node = root_reg;
            // Past the configured total the walk goes on but nothing is emitted.
            if (emit_count < total_reg) begin
               emit_count++;
               res.symbol   = node_tbl[hit].symbol;
               res.last     = 1'b0;
               res.finished = (emit_count >= total_reg);
               batch        = {batch, res};
            end
         end
      end
      if (batch.size() > 0)
         batch[batch.size() - 1].last = 1'b1;
      pending_symbols = {pending_symbols, batch};
   endfunction

   function automatic void apply_item(input req_item_type it);
      if (it.op == hfd_pkg::OP_LOAD) begin
         node_tbl[it.node_index].leaf   = it.node_is_leaf;
         node_tbl[it.node_index].symbol = it.node_symbol;
         node_tbl[it.node_index].left   = it.left_child;
         node_tbl[it.node_index].right  = it.right_child;
         if (!node_written[it.node_index]) begin
            node_written[it.node_index] = 1'b1;
            written_list = {written_list, it.node_index};
         end
      end else begin
         predict_decode(it.data_byte);
      end
   endfunction

   function automatic req_item_type make_load(input logic [hfd_pkg::IDX_W-1:0] idx,
                                              input logic leaf,
                                              input logic [hfd_pkg::SYM_W-1:0] sym,
                                              input logic [hfd_pkg::IDX_W-1:0] left,
                                              input logic [hfd_pkg::IDX_W-1:0] right);
      req_item_type it;
      it.op           = hfd_pkg::OP_LOAD;
      it.node_index   = idx;
      it.node_is_leaf = leaf;
      it.node_symbol  = sym;
      it.left_child   = left;
      it.right_child  = right;
      it.data_byte    = (hfd_pkg::DATA_W)'($urandom());
      return it;
   endfunction

   // Node fields of a decode item carry random content that the block must ignore.
   function automatic req_item_type make_decode(input logic [hfd_pkg::DATA_W-1:0] data_in);
      req_item_type it;
      it.op           = hfd_pkg::OP_DECODE;
      it.node_index   = (hfd_pkg::IDX_W)'($urandom());
      it.node_is_leaf = 1'($urandom());
      it.node_symbol  = (hfd_pkg::SYM_W)'($urandom());
      it.left_child   = (hfd_pkg::IDX_W)'($urandom());
      it.right_child  = (hfd_pkg::IDX_W)'($urandom());
      it.data_byte    = data_in;
      return it;
   endfunction

   function automatic logic [hfd_pkg::IDX_W-1:0] random_written();
      return written_list[$urandom_range(0, written_list.size() - 1)];
   endfunction

   // A stray node write; children always point at written entries so no walk
   // can ever reach an entry that was never loaded.
   function automatic req_item_type noise_load();
      logic [hfd_pkg::IDX_W-1:0] idx;
      idx = $urandom_range(0, 1) ? random_written() : (hfd_pkg::IDX_W)'($urandom());
      return make_load(idx, 1'($urandom()), (hfd_pkg::SYM_W)'($urandom()),
                       random_written(), random_written());
   endfunction

   // One request transfer, with the sender's bursts and gaps in front of it.
   task automatic send_item(input req_item_type it);
      @(negedge clock);
      if (gaps_enabled && burst_left == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      req_if.op           = it.op;
      req_if.node_index   = it.node_index;
      req_if.node_is_leaf = it.node_is_leaf;
      req_if.node_symbol  = it.node_symbol;
      req_if.left_child   = it.left_child;
      req_if.right_child  = it.right_child;
      req_if.data_byte    = it.data_byte;
      req_if.valid        = 1'b1;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (burst_left > 0)
         burst_left--;
      apply_item(it);
      items_sent++;
   endtask

   // Stop offering, let every expected symbol arrive, then allow a walk to finish.
   task automatic wait_idle();
      @(negedge clock);
      req_if.valid = 1'b0;
      burst_left   = 0;
      while (pending_symbols.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [hfd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] value);
      wait_idle();
      @(negedge clock);
      csr_if.index = idx;
      csr_if.data  = value;
      csr_if.valid = 1'b1;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      if (idx == hfd_pkg::CSR_ROOT) begin
         root_reg  = value[hfd_pkg::IDX_W-1:0];
         walk_node = root_reg;
      end else if (idx == hfd_pkg::CSR_TOTAL) begin
         total_reg = value;
      end
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   // Upper data bits are random; only the low index bits count.
   task automatic set_root(input logic [hfd_pkg::IDX_W-1:0] root);
      write_reg(hfd_pkg::CSR_ROOT, {(32 - hfd_pkg::IDX_W)'($urandom()), root});
   endtask

   // Load a random full binary tree with the given number of leaves. Leaves point
   // their unused children back into the tree. Loads go out in shuffled order.
   task automatic build_tree(input int leaves, input int want_root,
                             output logic [hfd_pkg::IDX_W-1:0] root_out);
      bit                        used [hfd_pkg::NODE_COUNT_DEF];
      logic [hfd_pkg::IDX_W-1:0] idx_set [$];
      logic [hfd_pkg::IDX_W-1:0] pool [$];
      req_item_type              loads [$];
      req_item_type              tmp;
      logic [hfd_pkg::IDX_W-1:0] pick;
      logic [hfd_pkg::IDX_W-1:0] a;
      logic [hfd_pkg::IDX_W-1:0] c;
      int                        n;
      int                        target;
      int                        j;
      n      = 2 * leaves - 1;
      target = (want_root >= 0) ? n - 1 : n;
      if (want_root >= 0)
         used[want_root] = 1'b1;
      while (idx_set.size() < target) begin
         pick = (hfd_pkg::IDX_W)'($urandom_range(0, hfd_pkg::NODE_COUNT_DEF - 1));
         if (!used[pick]) begin
            used[pick] = 1'b1;
            idx_set    = {idx_set, pick};
         end
      end
      if (want_root >= 0)
         idx_set = {idx_set, (hfd_pkg::IDX_W)'(want_root)};
      for (int k = 0; k < leaves; k++) begin
         loads = {loads, make_load(idx_set[k], 1'b1, (hfd_pkg::SYM_W)'($urandom()),
                                   idx_set[$urandom_range(0, n - 1)],
                                   idx_set[$urandom_range(0, n - 1)])};
         pool  = {pool, idx_set[k]};
      end
      // Merge two random subtrees under each inner node; the last one is the root.
      for (int k = leaves; k < n; k++) begin
         j = $urandom_range(0, pool.size() - 1);
         a = pool[j];
         pool.delete(j);
         j = $urandom_range(0, pool.size() - 1);
         c = pool[j];
         pool.delete(j);
         if ($urandom_range(0, 1))
            loads = {loads, make_load(idx_set[k], 1'b0, (hfd_pkg::SYM_W)'($urandom()),
                                      a, c)};
         else
            loads = {loads, make_load(idx_set[k], 1'b0, (hfd_pkg::SYM_W)'($urandom()),
                                      c, a)};
         pool = {pool, idx_set[k]};
      end
      for (int k = loads.size() - 1; k > 0; k--) begin
         j        = $urandom_range(0, k);
         tmp      = loads[k];
         loads[k] = loads[j];
         loads[j] = tmp;
      end
      foreach (loads[k])
         send_item(loads[k]);
      root_out = idx_set[n - 1];
   endtask

   // Response ready: a rotating stall pattern, replaced by a fresh one after each period,
   // with a long hold-off on request.
   initial begin : rsp_ready_driver
      logic [15:0] pattern;
      int          period;
      int          hold_count;
      rsp_if.ready = 1'b0;
      pattern      = 16'hFFFF;
      period       = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_if.ready = 1'b0;
            hold_count   = 0;
            while (hold_count < HOLD_CYCLES) begin
               @(negedge clock);
               hold_count++;
            end
         end
         if (period == 0) begin
            period  = 64;
            pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom());
         end
         period--;
         rsp_if.ready = pattern[0];
         pattern      = {pattern[0], pattern[15:1]};
      end
   end

   // Compare each response transfer with the oldest expected symbol.
   always @(posedge clock) begin : symbol_checker
      sym_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_symbols.size() == 0) begin
            report_mismatch("symbol with none expected", 32'(rsp_if.symbol), '0);
         end else begin
            want = pending_symbols.pop_front();
            if (rsp_if.symbol !== want.symbol)
               report_mismatch("symbol", 32'(rsp_if.symbol), 32'(want.symbol));
            if (rsp_if.last !== want.last)
               report_mismatch("last", 32'(rsp_if.last), 32'(want.last));
            if (rsp_if.finished !== want.finished)
               report_mismatch("finished", 32'(rsp_if.finished), 32'(want.finished));
         end
      end
   end

   // Total of zero at reset: the walk runs but emits nothing. Root at index 0.
   task automatic test_total_zero();
      logic [hfd_pkg::IDX_W-1:0] root;
      write_reg(hfd_pkg::CSR_TOTAL, 32'd0);
      set_root('0);
      build_tree(2, 0, root);
      send_item(make_decode(8'h00));
      send_item(make_decode(8'hFF));
      wait_idle();
   endtask

   // A leaf root at the top index emits its symbol on every bit.
   task automatic test_leaf_root();
      send_item(make_load(9'd511, 1'b1, 8'hFF, 9'd0, 9'd0));
      write_reg(hfd_pkg::CSR_TOTAL, 32'hFFFF_FFFF);
      set_root(9'd511);
      send_item(make_decode(8'hA5));
      send_item(make_load(9'd511, 1'b1, 8'h00, 9'd0, 9'd0));
      send_item(make_decode(8'h00));
      wait_idle();
   endtask

   task automatic test_deep_tree();
      logic [hfd_pkg::IDX_W-1:0] root;
      build_tree(5, -1, root);
      set_root(root);
      send_item(make_decode(8'h00));
      send_item(make_decode(8'hFF));
      send_item(make_decode((hfd_pkg::DATA_W)'($urandom())));
      wait_idle();
   endtask

   // Turn the node the walk is parked on into a leaf between two bytes.
   task automatic test_rewrite_mid_walk();
      send_item(make_decode(8'h6C));
      send_item(make_load(walk_node, 1'b1, (hfd_pkg::SYM_W)'($urandom()), root_reg,
                          random_written()));
      send_item(make_decode(8'h93));
      wait_idle();
   endtask

   // Reaching the total sets finished and suppresses the rest; spare indexes do nothing.
   task automatic test_total_limit();
      write_reg(hfd_pkg::CSR_TOTAL, emit_count + 32'd3);
      send_item(make_decode(8'hFF));
      send_item(make_decode(8'h0F));
      send_item(make_decode(8'hC3));
      write_reg(CSR_SPARE_A, $urandom());
      write_reg(CSR_SPARE_B, $urandom());
      send_item(make_decode(8'h5A));
      write_reg(hfd_pkg::CSR_TOTAL, 32'hFFFF_FFFF);
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering bytes.
   task automatic test_backpressure();
      logic [hfd_pkg::IDX_W-1:0] root;
      build_tree(4, -1, root);
      set_root(root);
      gaps_enabled = 1'b0;
      hold_request = 1'b1;
      repeat (14)
         send_item(make_decode((hfd_pkg::DATA_W)'($urandom())));
      gaps_enabled = 1'b1;
      wait_idle();
   endtask

   // Rounds of a fresh tree, a random total and a stream of bytes with stray loads.
   task automatic test_random_trees();
      logic [hfd_pkg::IDX_W-1:0] root;
      int                        first_item;
      first_item = items_sent;
      while (items_sent - first_item < RANDOM_ITEMS) begin
         gaps_enabled = ($urandom_range(0, 3) != 0);
         build_tree($urandom_range(2, 8), -1, root);
         set_root(root);
         if ($urandom_range(0, 3) == 0)
            write_reg(hfd_pkg::CSR_TOTAL, emit_count + 32'($urandom_range(0, 6)));
         else
            write_reg(hfd_pkg::CSR_TOTAL, 32'hFFFF_FFFF);
         repeat ($urandom_range(4, 12)) begin
            if ($urandom_range(0, 4) == 0)
               send_item(noise_load());
            send_item(make_decode((hfd_pkg::DATA_W)'($urandom())));
         end
      end
      gaps_enabled = 1'b1;
      wait_idle();
   endtask

   // Reset, then the tests in turn, then the verdict.
   initial begin
      req_if.valid        = 1'b0;
      req_if.op           = hfd_pkg::OP_LOAD;
      req_if.node_index   = '0;
      req_if.node_is_leaf = 1'b0;
      req_if.node_symbol  = '0;
      req_if.left_child   = '0;
      req_if.right_child  = '0;
      req_if.data_byte    = '0;
      csr_if.valid        = 1'b0;
      csr_if.index        = hfd_pkg::CSR_ROOT;
      csr_if.data         = '0;
      reset               = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_total_zero();
      test_leaf_root();
      test_deep_tree();
      test_rewrite_mid_walk();
      test_total_limit();
      test_backpressure();
      test_random_trees();

      wait_idle();
      repeat (FINAL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/hfd_pkg.sv
rtl/core/hfd_ifs.sv
rtl/core/hfd_node_mem.sv
rtl/core/huffman_tree_walk_decoder.sv
tb/huffman_tree_walk_decoder_tb.sv
